@@ rtl/hs_pkg.sv @@
// Package for the heap sorter block: word types and widths.
// Used by hs_cell, heap_sorter, heap_sorter_checker and the bench; depends on nothing.
package hs_pkg;

  localparam int unsigned VALUE_W = 32;

  // One input word: an element and its end-of-set mark.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } item_t;

  // One result word.
  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic                      overflow;
  } result_t;

  // A value with a valid bit, as held in a cell or handed between cells.
  typedef struct packed {
    logic                      vld;
    logic signed [VALUE_W-1:0] val;
  } cell_data_t;

endpackage

@@ rtl/heap_sorter.sv @@
// Top level of the sorter: a chain of DEPTH hs_cell instances and its controller.
// Depends on hs_pkg and hs_cell.
//
// Usage: drive a word on item_i and raise start_i; the word is taken at a rising
// edge where start_i is high and busy_o is low. Words are taken one per cycle
// while a set loads; words beyond DEPTH are dropped and the set is flagged.
// The word with last set closes the set. busy_o then rises, and the chain
// settles while the last carries travel to their place.
// After that the set leaves in ascending order, one result per cycle on
// result_o, marked by valid_o for exactly one cycle each; the final result
// carries last_out, and every result of a flagged set carries overflow.
// The n results of a set thus come back to back, once the settling walk
// through the cell chain has ended.
// The receiver cannot stall: results are not held. busy_o falls in the cycle
// the final result shows, so the next set may begin at once.
// Reset clears the valid bits of all cells, the element count and the overflow flag.
module heap_sorter
  import hs_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  item_t   item_i,
  output logic    busy_o,
  output logic    valid_o,
  output result_t result_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   drain_q;
  logic               ovf_q;
  logic               valid_q;
  result_t            result_q;

  logic               accept;
  logic               store;
  logic               shift;

  cell_data_t         carry_w [DEPTH+1];
  cell_data_t         hold_w  [DEPTH+1];

  assign accept = start_i && !busy_o;
  assign store  = accept && (count_q < CNT_W'(DEPTH));
  assign shift  = (state_q == ST_EMIT);

  // Feed of the first cell and the empty end beyond the last cell.
  assign carry_w[0]     = '{vld: store, val: item_i.value};
  assign hold_w[DEPTH]  = '{vld: 1'b0, val: '0};

  // The cell chain.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    hs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .carry_i (carry_w[g]),
      .right_i (hold_w[g+1]),
      .carry_o (carry_w[g+1]),
      .hold_o  (hold_w[g])
    );
  end

  // Controller: load, settle, then shift out from the first cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      count_q  <= '0;
      drain_q  <= '0;
      ovf_q    <= 1'b0;
      valid_q  <= 1'b0;
      result_q <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_LOAD: begin
          if (accept) begin
            if (store) begin
              count_q <= count_q + CNT_W'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (item_i.last) begin
              drain_q <= CNT_W'(DEPTH - 1);
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (drain_q == '0) begin
            state_q <= ST_EMIT;
          end else begin
            drain_q <= drain_q - CNT_W'(1);
          end
        end
        ST_EMIT: begin
          valid_q               <= 1'b1;
          result_q.sorted_value <= hold_w[0].val;
          result_q.last_out     <= (count_q == CNT_W'(1));
          result_q.overflow     <= ovf_q;
          count_q               <= count_q - CNT_W'(1);
          if (count_q == CNT_W'(1)) begin
            ovf_q   <= 1'b0;
            state_q <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign busy_o   = (state_q != ST_LOAD);
  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

@@ rtl/hs_cell.sv @@
// One cell of the sorting chain: holds one element and passes the larger one on.
// Depends on hs_pkg for cell_data_t.
module hs_cell
  import hs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  cell_data_t carry_i,
  input  cell_data_t right_i,
  output cell_data_t carry_o,
  output cell_data_t hold_o
);

  cell_data_t hold_q, hold_d;
  cell_data_t carry_q, carry_d;

  // Insert: keep the smaller of held and arriving values, pass the larger right.
  // Shift: take the right neighbor's content so the chain moves toward cell zero.
  always_comb begin
    hold_d  = hold_q;
    carry_d = '{vld: 1'b0, val: hold_q.val};
    if (shift_i) begin
      hold_d = right_i;
    end else if (carry_i.vld) begin
      if (!hold_q.vld) begin
        hold_d = carry_i;
      end else if (carry_i.val > hold_q.val) begin
        carry_d = carry_i;
      end else begin
        carry_d = '{vld: 1'b1, val: hold_q.val};
        hold_d  = carry_i;
      end
    end
  end

  // Only the valid bits are cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q.vld  <= 1'b0;
      carry_q.vld <= 1'b0;
    end else begin
      hold_q  <= hold_d;
      carry_q <= carry_d;
    end
  end

  assign carry_o = carry_q;
  assign hold_o  = hold_q;

endmodule

@@ rtl/heap_sorter_checker.sv @@
// Port-level checker for heap_sorter, attached by the bind at the end of this file.
// Depends on hs_pkg and the heap_sorter top level.
module heap_sorter_checker
  import hs_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start_i,
  input item_t   item_i,
  input logic    busy_o,
  input logic    valid_o,
  input result_t result_o
);

  // A closing word puts the block to work.
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && item_i.last |=> busy_o)
    else $error("block not busy after closing word");

  // Results of a set come back to back until the final one.
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !result_o.last_out |=> valid_o)
    else $error("gap inside a result burst");

  // Nothing follows the final result in the next cycle.
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.last_out |=> !valid_o)
    else $error("result after final word");

  // The overflow flag is the same on every result of one set.
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(valid_o) && !$past(result_o.last_out) |->
      result_o.overflow == $past(result_o.overflow))
    else $error("overflow flag changed within a set");

  // A result is only produced while the block was working.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result while idle");

endmodule

bind heap_sorter heap_sorter_checker u_heap_sorter_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .item_i   (item_i),
  .busy_o   (busy_o),
  .valid_o  (valid_o),
  .result_o (result_o)
);

@@ bench/heap_sorter_test.sv @@
// Self-checking bench for heap_sorter: loads sets of signed words and checks
// that each set comes back in ascending order with correct flags.
// Depends on hs_pkg and the heap_sorter RTL.
module heap_sorter_test
  import hs_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PRINT_CAP = 40;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  // Tracks the set being loaded and the sorted words still owed by the block.
  class sorted_set_board;
    logic signed [VALUE_W-1:0] held [DEPTH];
    int unsigned kept;
    bit dropped;
    result_t due_words [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned sets;
    int unsigned flagged_sets;

    function new();
      kept = 0;
      dropped = 1'b0;
      errors = 0;
      checked = 0;
      sets = 0;
      flagged_sets = 0;
    endfunction

    function void report(string what, logic signed [VALUE_W-1:0] exp_v,
                         logic signed [VALUE_W-1:0] got_v);
      errors++;
      if (errors <= PRINT_CAP) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, got_v);
      end
    endfunction

    // Notes an accepted input word; on the end of a set, sorts and queues results.
    function void take_word(item_t w);
      logic signed [VALUE_W-1:0] key;
      int unsigned i;
      int unsigned j;
      result_t r;
      if (kept < DEPTH) begin
        held[kept] = w.value;
        kept++;
      end else begin
        dropped = 1'b1;
      end
      if (!w.last) return;
      sets++;
      if (dropped) flagged_sets++;
      // Insertion sort into ascending signed order.
      for (i = 1; i < kept; i++) begin
        key = held[i];
        j = i;
        while (j > 0 && held[j-1] > key) begin
          held[j] = held[j-1];
          j--;
        end
        held[j] = key;
      end
      for (i = 0; i < kept; i++) begin
        r.sorted_value = held[i];
        r.last_out = (i + 1 == kept);
        r.overflow = dropped;
        due_words = {due_words, r};
      end
      kept = 0;
      dropped = 1'b0;
    endfunction

    // Compares one result word with the oldest owed word.
    function void check_word(result_t got);
      result_t exp_r;
      if (due_words.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP) begin
          $display("%0t: unexpected result: expected none, actual value=%0d last=%0b ovf=%0b",
                   $time, got.sorted_value, got.last_out, got.overflow);
        end
        return;
      end
      exp_r = due_words.pop_front();
      checked++;
      if (got.sorted_value !== exp_r.sorted_value)
        report("sorted_value", exp_r.sorted_value, got.sorted_value);
      if (got.last_out !== exp_r.last_out)
        report("last_out", exp_r.last_out, got.last_out);
      if (got.overflow !== exp_r.overflow)
        report("overflow", exp_r.overflow, got.overflow);
    endfunction
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    start_i;
  item_t   item_i;
  logic    busy_o;
  logic    valid_o;
  result_t result_o;

  sorted_set_board board;
  int unsigned idle_pct;
  int unsigned words_sent;
  int unsigned quiet_cycles;

  heap_sorter #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .item_i  (item_i),
    .busy_o  (busy_o),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  // Free-running 10 ns clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Every result word is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) board.check_word(result_o);
  end

  // Ends the run if neither side moves a word for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Picks an element: full range, a narrow band for duplicates, or an extreme, zero or minus one.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 15)) - 8;
      1: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Offers one word after random idle cycles and waits until it is taken.
  task automatic send_word(input logic signed [VALUE_W-1:0] v, input logic l);
    item_t w;
    w.value = v;
    w.last = l;
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (busy_o);
    board.take_word(w);
    words_sent++;
  endtask

  // Sends a whole set of n random elements, the final one marked last.
  task automatic send_set(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) send_word(pick_value(), k + 1 == n);
  endtask

  // Holds the sender off until every owed word has come back.
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (board.due_words.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    int unsigned rand_start;
    int unsigned size;
    int unsigned idle_by_phase [3];
    board = new();
    idle_by_phase[0] = 0;
    idle_by_phase[1] = 74;
    idle_by_phase[2] = 37;
    idle_pct = 0;
    words_sent = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a one-element set, the extremes, duplicates, reverse order.
    send_word(VAL_MIN, 1'b1);
    send_word(VAL_MAX, 1'b0);
    send_word(VAL_MIN, 1'b0);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(1, 1'b1);
    send_word(7, 1'b0);
    send_word(-3, 1'b0);
    send_word(7, 1'b0);
    send_word(-3, 1'b0);
    send_word(7, 1'b1);
    send_word(40, 1'b0);
    send_word(30, 1'b0);
    send_word(20, 1'b0);
    send_word(10, 1'b1);
    send_word(32'sh5555_5555, 1'b0);
    send_word(32'shAAAA_AAAA, 1'b1);
    wait_drained();

    // A set that fills the store and then drops a plain word and the word
    // marked last.
    send_set(DEPTH + 2);
    wait_drained();

    // Random small sets under changing sender idling.
    rand_start = words_sent;
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = idle_by_phase[phase];
      while (words_sent - rand_start < 15 * (phase + 1)) begin
        size = $urandom_range(1, 8);
        send_set(size);
      end
      wait_drained();
    end

    repeat (DEPTH + 8) @(posedge clk_i);
    $display("Sent %0d words in %0d sets (%0d with dropped words); checked %0d results.",
             words_sent, board.sets, board.flagged_sets, board.checked);
    $display("Sender idling covered 0, 74 and 37 percent; %0d mismatches.", board.errors);
    if (board.errors == 0 && board.due_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ heap_sorter.f @@
rtl/hs_pkg.sv
rtl/hs_cell.sv
rtl/heap_sorter.sv
rtl/heap_sorter_checker.sv
bench/heap_sorter_test.sv
